// ===== src/pid_position_drive_with_slew_macros.svh =====
// Assertion macros for the PID position drive block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PID_POSITION_DRIVE_WITH_SLEW_MACROS_SVH
`define PID_POSITION_DRIVE_WITH_SLEW_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PDWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PDWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pdws_pkg.sv =====
// Shared types and constants for the PID position drive block.
// No dependencies; imported by every module of the block.
package pdws_pkg;

    // Field and register widths
    localparam int POS_BITS           = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int GAIN_W             = 20;
    localparam int BOUND_W            = 16;
    localparam int OMAX_W             = 7;
    localparam int ACCEL_W            = 8;
    localparam int DECEL_W            = 9;
    localparam int DRIVE_W            = 8;
    localparam int TICK_W             = 7;
    localparam int INTEG_W            = 32;
    localparam int CFG_DATA_W         = 20;
    localparam int CFG_IDX_W          = 3;

    // Settling bands and tick limits (control period of 20 ms)
    localparam int NEAR_BAND    = 30;
    localparam int FINE_BAND    = 7;
    localparam int TICK_PERIOD  = 20;
    localparam int SETTLE_LIMIT = 1000 / TICK_PERIOD;
    localparam int EXIT_LIMIT   = 200 / TICK_PERIOD;
    localparam int TICK_SAT     = (1 << TICK_W) - 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_INTEG_LOW   = 3'd3,
        CFG_INTEG_HIGH  = 3'd4,
        CFG_OUTPUT_MAX  = 3'd5,
        CFG_ACCEL_LIMIT = 3'd6,
        CFG_DECEL_LIMIT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [BOUND_W-1:0] integ_low_bound;
        logic [BOUND_W-1:0] integ_high_bound;
        logic [OMAX_W-1:0]  output_max;
        logic [ACCEL_W-1:0] accel_limit;
        logic [DECEL_W-1:0] decel_limit;
    } cfg_t;

    typedef struct packed {
        logic                       action;
        logic signed [POS_BITS-1:0] goal;
        logic signed [POS_BITS-1:0] position;
    } pdws_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]  drive;
        logic                       settled;
        logic signed [POS_BITS-1:0] position_error;
    } pdws_out_t;

endpackage

// ===== src/pdws_cfg_regs.sv =====
// Configuration register bank for the PID position drive block.
// Depends on pdws_pkg for the register layout and indexes.
module pdws_cfg_regs
    import pdws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:      cfg_next.gain_p           = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:      cfg_next.gain_i           = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:      cfg_next.gain_d           = cfg_data[GAIN_W-1:0];
                CFG_INTEG_LOW:   cfg_next.integ_low_bound  = cfg_data[BOUND_W-1:0];
                CFG_INTEG_HIGH:  cfg_next.integ_high_bound = cfg_data[BOUND_W-1:0];
                CFG_OUTPUT_MAX:  cfg_next.output_max       = cfg_data[OMAX_W-1:0];
                CFG_ACCEL_LIMIT: cfg_next.accel_limit      = cfg_data[ACCEL_W-1:0];
                CFG_DECEL_LIMIT: cfg_next.decel_limit      = cfg_data[DECEL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset to the default tuning
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p           <= GAIN_W'(26214);
            cfg_reg.gain_i           <= GAIN_W'(655);
            cfg_reg.gain_d           <= GAIN_W'(81920);
            cfg_reg.integ_low_bound  <= BOUND_W'(10);
            cfg_reg.integ_high_bound <= BOUND_W'(60);
            cfg_reg.output_max       <= OMAX_W'(127);
            cfg_reg.accel_limit      <= ACCEL_W'(4);
            cfg_reg.decel_limit      <= DECEL_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pdws_in_stage.sv =====
// Input register stage: captures one transaction and hands it to the control math.
// Depends on pdws_pkg for the input payload type.
module pdws_in_stage
    import pdws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pdws_in_t in_data,
    input  logic     out_space,
    output logic     fire,
    output pdws_in_t q_data
);

    logic     q_valid_reg;
    logic     q_valid_next;
    pdws_in_t q_data_reg;
    logic     take;

    // Advance when the result register can take the step
    assign fire     = q_valid_reg && out_space;
    assign in_ready = !q_valid_reg || out_space;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (take)
            q_valid_next = 1'b1;
        else if (fire)
            q_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= q_valid_next;
    end

    // Capture the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            q_data_reg <= in_data;
    end

    assign q_data = q_data_reg;

endmodule

// ===== src/pdws_core.sv =====
// PID step with integral window, drive clamp, slew limit and settle counters.
// Holds the per-move state; depends on pdws_pkg for types and constants.
module pdws_core
    import pdws_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  pdws_in_t  step,
    input  cfg_t      cfg,
    output pdws_out_t result
);

    localparam int DIFF_W  = POS_BITS + 1;
    localparam int CMP_W   = (POS_BITS > BOUND_W) ? POS_BITS : BOUND_W;
    localparam int WIDE_W  = (DIFF_W > INTEG_W) ? DIFF_W : INTEG_W;
    localparam int SUM_W   = WIDE_W + GAIN_W + 3;
    localparam int SLEW_W  = DECEL_W + 1;
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [INTEG_W-1:0]  INT_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0]  INT_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Per-move state
    logic signed [POS_BITS-1:0] target_reg, target_next;
    logic signed [POS_BITS-1:0] prev_error_reg, prev_error_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [DRIVE_W-1:0]  prev_drive_reg, prev_drive_next;
    logic [TICK_W-1:0]          settle_reg, settle_next;
    logic [TICK_W-1:0]          exit_reg, exit_next;

    logic signed [DIFF_W-1:0]          diff;
    logic signed [POS_BITS-1:0]        err;
    logic signed [DIFF_W-1:0]          deriv;
    logic [POS_BITS-1:0]               aerr;
    logic                              in_window;
    logic signed [INTEG_W:0]           integ_sum;
    logic signed [INTEG_W-1:0]         integ_sat;
    logic signed [INTEG_W-1:0]         integ_upd;
    logic signed [POS_BITS+GAIN_W:0]   prod_p;
    logic signed [INTEG_W+GAIN_W:0]    prod_i;
    logic signed [DIFF_W+GAIN_W:0]     prod_d;
    logic signed [SUM_W-1:0]           pid_sum;
    logic [SUM_W-1:0]                  sum_mag;
    logic [SUM_W-1:0]                  pid_whole;
    logic [OMAX_W-1:0]                 pid_mag;
    logic                              pid_neg;
    logic [SLEW_W-1:0]                 pid_mag_w;
    logic [SLEW_W-1:0]                 last_mag;
    logic signed [SLEW_W-1:0]          last_w;
    logic signed [SLEW_W-1:0]          rise_amt;
    logic signed [SLEW_W-1:0]          fall_amt;
    logic signed [DRIVE_W-1:0]         pid_drive;
    logic signed [DRIVE_W-1:0]         drive;
    logic                              near;
    logic                              fine;
    logic [TICK_W-1:0]                 settle_upd;
    logic [TICK_W-1:0]                 exit_upd;
    logic                              settled;

    // Error: saturate target minus position to the position range
    always_comb
    begin
        diff = DIFF_W'(target_reg) - DIFF_W'(step.position);
        if (diff[DIFF_W-1] != diff[DIFF_W-2])
            err = diff[DIFF_W-1] ? POS_MIN : POS_MAX;
        else
            err = diff[POS_BITS-1:0];
        deriv = DIFF_W'(err) - DIFF_W'(prev_error_reg);
        aerr  = err[POS_BITS-1] ? POS_BITS'(-err) : POS_BITS'(err);
    end

    // Integrate only inside the error window; saturate to 32 bits
    always_comb
    begin
        in_window = (CMP_W'(aerr) < CMP_W'(cfg.integ_high_bound)) &&
                    (CMP_W'(aerr) > CMP_W'(cfg.integ_low_bound));
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_sat = integ_sum[INTEG_W] ? INT_MIN : INT_MAX;
        else
            integ_sat = integ_sum[INTEG_W-1:0];
        integ_upd = in_window ? integ_sat : '0;
    end

    // Three gain products, summed in Q.GAIN_FRAC_BITS
    always_comb
    begin
        prod_p  = (POS_BITS+GAIN_W+1)'(err) *
                  (POS_BITS+GAIN_W+1)'($signed({1'b0, cfg.gain_p}));
        prod_i  = (INTEG_W+GAIN_W+1)'(integ_upd) *
                  (INTEG_W+GAIN_W+1)'($signed({1'b0, cfg.gain_i}));
        prod_d  = (DIFF_W+GAIN_W+1)'(deriv) *
                  (DIFF_W+GAIN_W+1)'($signed({1'b0, cfg.gain_d}));
        pid_sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    end

    // Truncate toward zero and clamp the magnitude to output_max (never above 127)
    always_comb
    begin
        pid_neg   = pid_sum[SUM_W-1];
        sum_mag   = pid_neg ? SUM_W'(-pid_sum) : SUM_W'(pid_sum);
        pid_whole = sum_mag >> GAIN_FRAC_BITS;
        if (pid_whole > SUM_W'(cfg.output_max))
            pid_mag = cfg.output_max;
        else
            pid_mag = pid_whole[OMAX_W-1:0];
        pid_drive = pid_neg ? -DRIVE_W'({1'b0, pid_mag}) : DRIVE_W'({1'b0, pid_mag});
    end

    // Slew limit against the previous drive
    always_comb
    begin
        pid_mag_w = SLEW_W'(pid_mag);
        last_w    = SLEW_W'(prev_drive_reg);
        last_mag  = last_w[SLEW_W-1] ? SLEW_W'(-last_w) : SLEW_W'(last_w);
        rise_amt  = pid_neg ? -SLEW_W'(cfg.accel_limit) : SLEW_W'(cfg.accel_limit);
        fall_amt  = prev_drive_reg[DRIVE_W-1] ? -SLEW_W'(cfg.decel_limit)
                                              : SLEW_W'(cfg.decel_limit);
        drive = pid_drive;
        if (pid_mag_w > last_mag)
        begin
            if (pid_mag_w > last_mag + SLEW_W'(cfg.accel_limit))
                drive = DRIVE_W'(last_w + rise_amt);
        end
        else if (pid_mag_w + SLEW_W'(cfg.decel_limit) < last_mag)
        begin
            drive = DRIVE_W'(last_w - fall_amt);
        end
    end

    // Settle and exit counters, saturating
    always_comb
    begin
        near       = aerr < POS_BITS'(NEAR_BAND);
        fine       = aerr < POS_BITS'(FINE_BAND);
        settle_upd = settle_reg;
        exit_upd   = '0;
        if (near)
        begin
            if (fine)
                settle_upd = (settle_reg == TICK_W'(TICK_SAT)) ? settle_reg
                                                               : settle_reg + TICK_W'(1);
            else
                settle_upd = '0;
            exit_upd = (exit_reg == TICK_W'(TICK_SAT)) ? exit_reg : exit_reg + TICK_W'(1);
        end
        settled = near && ((settle_upd > TICK_W'(SETTLE_LIMIT)) ||
                           (exit_upd > TICK_W'(EXIT_LIMIT)));
    end

    // Select state update and result: start clears, tick advances
    always_comb
    begin
        target_next     = target_reg;
        prev_error_next = prev_error_reg;
        integ_next      = integ_reg;
        prev_drive_next = prev_drive_reg;
        settle_next     = settle_reg;
        exit_next       = exit_reg;
        result          = '0;
        if (step.action)
        begin
            target_next     = step.goal;
            prev_error_next = '0;
            integ_next      = '0;
            prev_drive_next = '0;
            settle_next     = '0;
            exit_next       = '0;
        end
        else
        begin
            prev_error_next       = err;
            integ_next            = integ_upd;
            prev_drive_next       = drive;
            settle_next           = settle_upd;
            exit_next             = exit_upd;
            result.drive          = drive;
            result.settled        = settled;
            result.position_error = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            prev_error_reg <= '0;
            integ_reg      <= '0;
            prev_drive_reg <= '0;
            settle_reg     <= '0;
            exit_reg       <= '0;
        end
        else if (fire)
        begin
            target_reg     <= target_next;
            prev_error_reg <= prev_error_next;
            integ_reg      <= integ_next;
            prev_drive_reg <= prev_drive_next;
            settle_reg     <= settle_next;
            exit_reg       <= exit_next;
        end
    end

endmodule

// ===== src/pdws_out_stage.sv =====
// Result register stage: holds one result transaction until the consumer takes it.
// Depends on pdws_pkg for the output payload type.
module pdws_out_stage
    import pdws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  pdws_out_t result,
    output logic      out_space,
    output logic      out_valid,
    input  logic      out_ready,
    output pdws_out_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    pdws_out_t data_reg;

    // Free when empty or being drained this cycle
    assign out_space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/pid_position_drive_with_slew.sv =====
// PID position drive with slew limit, one wheel side.
// The accepted input transaction passes the input register, then the result register;
// throughput: one transaction per cycle while out_ready does not stall the output. The PID
// step with its three gain multiplies and the state update run combinationally in between.
// Reset: rst_n (async, active low) empties both stages, zeroes the move state and loads
// the default gains and limits.
module pid_position_drive_with_slew
    import pdws_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdws_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pdws_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "pid_position_drive_with_slew_macros.svh"

    cfg_t      cfg;
    pdws_in_t  q_data;
    pdws_out_t result;
    logic      fire;
    logic      out_space;

    pdws_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdws_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_space (out_space),
        .fire      (fire),
        .q_data    (q_data)
    );

    pdws_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .step   (q_data),
        .cfg    (cfg),
        .result (result)
    );

    pdws_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .out_space (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A start step always answers with an all-zero result
    `PDWS_ASSERT_NEXT(a_start_zero, fire && q_data.action,
        out_valid && out_data.drive == '0 && !out_data.settled &&
        out_data.position_error == '0, "start step produced a nonzero result")

    // Settled is only reported inside the near band
    `PDWS_ASSERT_NOW(a_settled_near, out_valid && out_data.settled,
        out_data.position_error < POS_BITS'(NEAR_BAND) &&
        out_data.position_error > -POS_BITS'(NEAR_BAND), "settled outside near band")

    // Input stalls only when both stages are full and the output is blocked
    `PDWS_ASSERT_NOW(a_stall_cause, !in_ready,
        out_valid && !out_ready && !fire, "input stalled without downstream backpressure")

    // Drive magnitude never reaches the negative full-scale code
    `PDWS_ASSERT_NOW(a_drive_range, out_valid,
        out_data.drive != {1'b1, {(DRIVE_W-1){1'b0}}}, "drive outside +-127")

endmodule
